// File: rtl/nsc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nsc_pkg
// shared types, character constants and decode functions for the
// nmea sentence checker
// ----------------------------------------------------------------------------
package nsc_pkg;

	localparam int BYTE_W  = 8;
	localparam int LEN_W   = 8;
	localparam int HDR_LEN = 5;
	localparam int MIN_LEN = 10;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [HDR_LEN-1:0][BYTE_W-1:0] hdr_t;

	localparam byte_t CHR_LF   = 8'h0A;
	localparam byte_t CHR_STAR = 8'h2A;

	typedef enum logic [3:0] {
		SENT_NONE = 4'd0,
		SENT_GGA  = 4'd1,
		SENT_GLL  = 4'd2,
		SENT_GSA  = 4'd3,
		SENT_GSV  = 4'd4,
		SENT_RMC  = 4'd5,
		SENT_VTG  = 4'd6,
		SENT_TXT  = 4'd7,
		SENT_PMT  = 4'd8
	} sent_t;

	// snapshot of a finished line, handed from tracker to verifier
	typedef struct packed {
		byte_t  star;
		byte_t  hex_hi;
		byte_t  hex_lo;
		byte_t  xor_sum;
		hdr_t   header;
		len_t   length;
		logic   ended_full;
		logic   long_enough;
	} line_snap_t;

	function automatic byte_t hex_digit(input logic [3:0] nib);
		byte_t d;
		if (nib < 4'd10) begin
			d = 8'h30 + {4'h0, nib};
		end else begin
			d = 8'h41 + {4'h0, nib} - 8'd10;
		end
		return d;
	endfunction

	// compare the header against a five character string (first char in msb)
	function automatic logic hdr_is(input hdr_t h, input logic [8*HDR_LEN-1:0] s);
		logic m;
		m = 1'b1;
		for (int i = 0; i < HDR_LEN; i++) begin
			if (h[i] != s[8*HDR_LEN-1-8*i -: 8]) begin
				m = 1'b0;
			end
		end
		return m;
	endfunction

	function automatic sent_t classify(input hdr_t h);
		sent_t t;
		if (hdr_is(h, "GPGGA") || hdr_is(h, "GNGGA")) begin
			t = SENT_GGA;
		end else if (hdr_is(h, "GPGLL") || hdr_is(h, "GNGLL")) begin
			t = SENT_GLL;
		end else if (hdr_is(h, "GPGSA") || hdr_is(h, "GNGSA") || hdr_is(h, "BDGSA")) begin
			t = SENT_GSA;
		end else if (hdr_is(h, "GPGSV") || hdr_is(h, "GLGSV") || hdr_is(h, "BDGSV")) begin
			t = SENT_GSV;
		end else if (hdr_is(h, "GPRMC") || hdr_is(h, "GNRMC")) begin
			t = SENT_RMC;
		end else if (hdr_is(h, "GPVTG")) begin
			t = SENT_VTG;
		end else if (hdr_is(h, "GPTXT")) begin
			t = SENT_TXT;
		end else if (h[0] == 8'h50 && h[1] == 8'h4D && h[2] == 8'h54) begin
			t = SENT_PMT;
		end else begin
			t = SENT_NONE;
		end
		return t;
	endfunction

endpackage
`default_nettype wire

// File: rtl/nsc_rx_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nsc_rx_if
// received byte channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface nsc_rx_if import nsc_pkg::*; ();
	logic  valid;
	logic  ready;
	byte_t rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// File: rtl/nsc_res_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nsc_res_if
// per-line result channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface nsc_res_if import nsc_pkg::*; ();
	logic        valid;
	logic        ready;
	logic        checksum_ok;
	len_t        line_length;
	logic        ended_full;
	logic [3:0]  sentence_type;

	modport source (output valid, output checksum_ok, output line_length,
		output ended_full, output sentence_type, input ready);
	modport sink (input valid, input checksum_ok, input line_length,
		input ended_full, input sentence_type, output ready);
endinterface
`default_nettype wire

// File: rtl/nsc_line_tracker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nsc_line_tracker
// byte count, running xor and short history; snapshots each finished line
// ----------------------------------------------------------------------------
module nsc_line_tracker import nsc_pkg::*; #(
	parameter int LINE_MAX = 128
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	nsc_rx_if.sink          rx,
	output line_snap_t      snap_s1,
	output logic            snap_valid_s1,
	input  wire logic       snap_ready
);

	len_t  count_q;
	byte_t xor_q;
	byte_t xhist_q [HDR_LEN];
	byte_t recent_q [HDR_LEN];
	hdr_t  header_q;

	logic            fire;
	logic [LEN_W:0]  len_w;
	logic            is_lf;
	logic            full;
	logic            done;

	assign rx.ready = !snap_valid_s1 || snap_ready;
	assign fire     = rx.valid && rx.ready;
	assign len_w    = {1'b0, count_q} + 1'b1;
	assign is_lf    = (rx.rx_byte == CHR_LF);
	assign full     = (len_w >= (LEN_W+1)'(LINE_MAX));
	assign done     = is_lf || full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			xor_q    <= '0;
			header_q <= '0;
			for (int i = 0; i < HDR_LEN; i++) begin
				xhist_q[i]  <= '0;
				recent_q[i] <= '0;
			end
		end else if (fire) begin
			if (done) begin
				count_q  <= '0;
				xor_q    <= '0;
				header_q <= '0;
				for (int i = 0; i < HDR_LEN; i++) begin
					xhist_q[i]  <= '0;
					recent_q[i] <= '0;
				end
			end else begin
				count_q <= len_w[LEN_W-1:0];
				for (int i = HDR_LEN-1; i > 0; i--) begin
					xhist_q[i]  <= xhist_q[i-1];
					recent_q[i] <= recent_q[i-1];
				end
				xhist_q[0]  <= xor_q;
				recent_q[0] <= rx.rx_byte;
				if (count_q != '0) begin
					xor_q <= xor_q ^ rx.rx_byte;
				end
				for (int i = 0; i < HDR_LEN; i++) begin
					if (count_q == len_t'(i + 1)) begin
						header_q[i] <= rx.rx_byte;
					end
				end
			end
		end
	end

	// star sits five from the end: four bytes back from the one being taken
	always_ff @(posedge clk) begin
		if (fire && done) begin
			snap_s1.star        <= recent_q[3];
			snap_s1.hex_hi      <= recent_q[2];
			snap_s1.hex_lo      <= recent_q[1];
			snap_s1.xor_sum     <= xhist_q[3];
			snap_s1.header      <= header_q;
			snap_s1.length      <= len_w[LEN_W-1:0];
			snap_s1.ended_full  <= !is_lf;
			snap_s1.long_enough <= (len_w > (LEN_W+1)'(MIN_LEN));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_valid_s1 <= 1'b0;
		end else if (fire && done) begin
			snap_valid_s1 <= 1'b1;
		end else if (snap_ready) begin
			snap_valid_s1 <= 1'b0;
		end
	end

endmodule
`default_nettype wire

// File: rtl/nsc_verify.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nsc_verify
// checksum compare and header decode into the result register
// ----------------------------------------------------------------------------
module nsc_verify import nsc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire line_snap_t snap_s1,
	input  wire logic       snap_valid_s1,
	output logic            snap_ready,
	nsc_res_if.source       res
);

	logic  valid_q;
	logic  ok;
	sent_t kind;

	assign ok = snap_s1.long_enough && (snap_s1.star == CHR_STAR)
		&& (snap_s1.hex_hi == hex_digit(snap_s1.xor_sum[7:4]))
		&& (snap_s1.hex_lo == hex_digit(snap_s1.xor_sum[3:0]));
	assign kind = ok ? classify(snap_s1.header) : SENT_NONE;

	assign snap_ready = !valid_q || res.ready;
	assign res.valid  = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (snap_ready) begin
			valid_q <= snap_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (snap_ready && snap_valid_s1) begin
			res.checksum_ok   <= ok;
			res.line_length   <= snap_s1.length;
			res.ended_full    <= snap_s1.ended_full;
			res.sentence_type <= kind;
		end
	end

endmodule
`default_nettype wire

// File: rtl/nmea_sentence_checker_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nmea_sentence_checker_core
// slices received bytes into lines and checks each line's nmea checksum
// ----------------------------------------------------------------------------
// throughput: one byte per cycle; the byte path never waits unless a
//   finished line is still held in both the snapshot and result registers
// result path: the line feed (or filling byte) is registered into the line
//   snapshot, then into the result register
// reset: arst_n clears the line count, running xor, history and header bytes,
//   and empties both stages; no clearing pass is needed
module nmea_sentence_checker_core import nsc_pkg::*; #(
	parameter int LINE_MAX = 128
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	nsc_rx_if.sink     in_ch,
	nsc_res_if.source  out_ch
);

	// snapshot of the line that just ended, waiting for the verifier
	line_snap_t snap_s1;
	logic       snap_valid_s1;
	logic       snap_ready;

	// stage 1: count bytes, fold the xor, keep the last five bytes and the
	// xor value seen before each, capture the five header characters
	nsc_line_tracker #(
		.LINE_MAX (LINE_MAX)
	) u_tracker (
		.clk           (clk),
		.arst_n        (arst_n),
		.rx            (in_ch),
		.snap_s1       (snap_s1),
		.snap_valid_s1 (snap_valid_s1),
		.snap_ready    (snap_ready)
	);

	// stage 2: star and hex digit compare, sentence type decode, result
	// register that also acts as the skid between line ends and the sink
	nsc_verify u_verify (
		.clk           (clk),
		.arst_n        (arst_n),
		.snap_s1       (snap_s1),
		.snap_valid_s1 (snap_valid_s1),
		.snap_ready    (snap_ready),
		.res           (out_ch)
	);

endmodule
`default_nettype wire

// File: sim/nmea_sentence_checker_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nmea_sentence_checker_core_test
// drives received bytes into the line slicer and checks every line report
// against a cycle-free model of the checker: length, fill flag, checksum
// verdict and sentence type, under random idling and a long result hold-off
// ----------------------------------------------------------------------------
module nmea_sentence_checker_core_test;
	import nsc_pkg::*;

	localparam int CLK_PERIOD   = 20;
	localparam int RESET_CYCLES = 11;
	localparam int LINE_MAX     = 128;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int RAND_BYTES   = 120;
	localparam int RAND_LINES   = 20;

	// how the two hex digits after the star are written
	typedef enum {CS_GOOD, CS_LOWER, CS_BAD} cs_style_t;

	// one expected line report
	typedef struct packed {
		logic  chk_ok;
		len_t  length;
		logic  full;
		sent_t stype;
	} line_report_t;

	typedef byte_t byte_q_t [$];

	logic clk = 1'b0;
	logic arst_n;

	nsc_rx_if  rx ();
	nsc_res_if res ();

	nmea_sentence_checker_core #(
		.LINE_MAX(LINE_MAX)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (rx),
		.out_ch (res)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// model state of the line being gathered
	byte_t line_cnt;
	byte_t line_xor;
	byte_t xor_trail  [5];
	byte_t byte_trail [5];
	byte_t hdr_seen   [5];

	line_report_t pending_reports [$];

	// idle control shared by the driving processes
	logic tx_quiet      = 1'b0;
	logic rx_quiet      = 1'b0;
	logic hold_off_req  = 1'b0;

	int errors          = 0;
	int bytes_sent      = 0;
	int lines_predicted = 0;
	int lines_checked   = 0;
	int good_lines      = 0;
	int full_lines      = 0;
	int input_stalls    = 0;
	int cycle_cnt       = 0;

	// header pool: every known talker/type pair, a PMT header and one that decodes to nothing
	string hdr_pool [16] = '{"GPGGA", "GNGGA", "GPGLL", "GNGLL", "GPGSA", "GNGSA",
		"BDGSA", "GPGSV", "GLGSV", "BDGSV", "GPRMC", "GNRMC", "GPVTG", "GPTXT",
		"PMTK314", "GPZDA"};

	// ------------------------------------------------------------------
	// line model
	// ------------------------------------------------------------------

	function automatic void clear_line();
		line_cnt = '0;
		line_xor = '0;
		for (int i = 0; i < 5; i++) begin
			xor_trail[i]  = '0;
			byte_trail[i] = '0;
			hdr_seen[i]   = '0;
		end
	endfunction

	// ascii hex digit, uppercase only
	function automatic byte_t to_hex(input logic [3:0] n);
		return (n < 4'd10) ? 8'h30 + n : 8'h37 + n;
	endfunction

	function automatic sent_t header_type();
		logic [39:0] hdr_word;
		hdr_word = {hdr_seen[0], hdr_seen[1], hdr_seen[2], hdr_seen[3], hdr_seen[4]};
		case (hdr_word)
			"GPGGA", "GNGGA":          return SENT_GGA;
			"GPGLL", "GNGLL":          return SENT_GLL;
			"GPGSA", "GNGSA", "BDGSA": return SENT_GSA;
			"GPGSV", "GLGSV", "BDGSV": return SENT_GSV;
			"GPRMC", "GNRMC":          return SENT_RMC;
			"GPVTG":                   return SENT_VTG;
			"GPTXT":                   return SENT_TXT;
			default:                   return (hdr_word[39:16] == "PMT") ? SENT_PMT : SENT_NONE;
		endcase
	endfunction

	// folds one accepted byte into the line; returns 1 when the line closes
	function automatic logic fold_byte(input byte_t b, output line_report_t rep);
		byte_t       pos;
		int unsigned len;
		logic        at_lf;
		logic        at_full;
		logic        ok;
		int          i;
		rep = '0;
		pos = line_cnt;
		for (i = 4; i > 0; i--) begin
			xor_trail[i]  = xor_trail[i-1];
			byte_trail[i] = byte_trail[i-1];
		end
		xor_trail[0]  = line_xor;
		byte_trail[0] = b;
		// the leading byte stays out of the sum and the header
		if (pos >= 1) begin
			line_xor = line_xor ^ b;
			if (pos <= 5)
				hdr_seen[pos-1] = b;
		end
		len     = pos + 1;
		at_lf   = (b == CHR_LF);
		at_full = (len >= LINE_MAX);
		if (!at_lf && !at_full) begin
			line_cnt = len_t'(len);
			return 1'b0;
		end
		// star five back from the end, then the sum taken just before the star
		ok = (len > 10) && (byte_trail[4] == CHR_STAR)
			&& (byte_trail[3] == to_hex(xor_trail[4][7:4]))
			&& (byte_trail[2] == to_hex(xor_trail[4][3:0]));
		rep.chk_ok = ok;
		rep.length = len_t'(len);
		rep.full   = !at_lf;
		rep.stype  = ok ? header_type() : SENT_NONE;
		clear_line();
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// sentence builders
	// ------------------------------------------------------------------

	function automatic byte_t xor_of(input string s);
		byte_t acc;
		acc = '0;
		for (int i = 0; i < s.len(); i++)
			acc = acc ^ s[i];
		return acc;
	endfunction

	// '$' body '*' hh CR LF, with the digits written as asked
	function automatic string nmea_text(input string body, input cs_style_t style);
		byte_t cs;
		cs = xor_of(body);
		case (style)
			CS_GOOD:  return $sformatf("$%s*%02X\r\n", body, cs);
			CS_LOWER: return $sformatf("$%s*%02x\r\n", body, cs);
			default:  return $sformatf("$%s*%02X\r\n", body, cs ^ (8'h01 << $urandom_range(0, 7)));
		endcase
	endfunction

	// digits, punctuation and uppercase letters, never '$' or '*'
	function automatic byte_t field_char();
		return byte_t'($urandom_range(8'h2C, 8'h5A));
	endfunction

	function automatic string make_body(input int n_chars);
		string body;
		body = hdr_pool[$urandom_range(0, $size(hdr_pool) - 1)];
		repeat (n_chars)
			body = $sformatf("%s%c", body, field_char());
		return body;
	endfunction

	// ------------------------------------------------------------------
	// request drivers
	// ------------------------------------------------------------------

	// offers one byte, holds it until taken, then updates the model
	task automatic send_byte(input byte_t b);
		int           gap;
		line_report_t rep;
		gap = tx_quiet ? 0 : $urandom_range(0, 7);
		repeat (gap) begin
			@(negedge clk);
			rx.valid = 1'b0;
		end
		@(negedge clk);
		rx.valid   = 1'b1;
		rx.rx_byte = b;
		do @(posedge clk); while (rx.ready !== 1'b1);
		bytes_sent++;
		if (fold_byte(b, rep)) begin
			pending_reports.push_back(rep);
			lines_predicted++;
		end
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic send_bytes(input byte_q_t q);
		foreach (q[i])
			send_byte(q[i]);
	endtask

	// printable bytes with no line feed, to fill the line store
	task automatic send_filler(input int n);
		repeat (n)
			send_byte(field_char());
	endtask

	// result side: random stall per report, or one long hold-off on request
	initial begin : result_sink
		int stall;
		res.ready = 1'b0;
		forever begin
			if (hold_off_req) begin
				stall = HOLD_CYCLES;
				hold_off_req = 1'b0;
			end else begin
				stall = rx_quiet ? 0 : $urandom_range(0, 7);
			end
			repeat (stall) begin
				@(negedge clk);
				res.ready = 1'b0;
			end
			@(negedge clk);
			res.ready = 1'b1;
			do @(posedge clk); while (res.valid !== 1'b1);
		end
	end

	// ------------------------------------------------------------------
	// report checker
	// ------------------------------------------------------------------

	task automatic check_field(input string name, input logic [7:0] want_v,
		input logic [7:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t ns: %s mismatch, expected %0h, actual %0h",
				$time, name, want_v, got_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin : report_check
		line_report_t want;
		if (res.valid === 1'b1 && res.ready === 1'b1) begin
			if (pending_reports.size() == 0) begin
				$display("%0t ns: unexpected line report, length %0d", $time, res.line_length);
				errors++;
			end else begin
				want = pending_reports.pop_front();
				check_field("checksum_ok", {7'h0, want.chk_ok}, {7'h0, res.checksum_ok});
				check_field("line_length", want.length, res.line_length);
				check_field("ended_full", {7'h0, want.full}, {7'h0, res.ended_full});
				check_field("sentence_type", {4'h0, want.stype}, {4'h0, res.sentence_type});
				lines_checked++;
				if (want.chk_ok)
					good_lines++;
				if (want.full)
					full_lines++;
			end
		end
	end

	// cycle budget and input stall count
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (rx.valid === 1'b1 && rx.ready !== 1'b1)
			input_stalls <= input_stalls + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("%0t ns: timeout, %0d line reports still outstanding",
				$time, pending_reports.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// one good sentence per header in the pool, so every type code shows up
	task automatic test_header_types();
		foreach (hdr_pool[i])
			send_text(nmea_text(hdr_pool[i], CS_GOOD));
	endtask

	// lowercase digits, a wrong sum, and a star one place too early
	task automatic test_checksum_faults();
		string body;
		byte_t cs;
		body = "GPTXT,01,01,02,ANTENNA";
		cs = xor_of(body);
		// a lowercase miss needs at least one letter digit
		while (cs[7:4] < 4'd10 && cs[3:0] < 4'd10) begin
			body = $sformatf("%s%c", body, field_char());
			cs = xor_of(body);
		end
		send_text(nmea_text(body, CS_LOWER));
		send_text(nmea_text("GPGGA,092750.000,5321.6802,N", CS_BAD));
		send_text($sformatf("$%s*%02X7\r\n", "GPVTG,9", xor_of("GPVTG,9")));
	endtask

	// bare line feed, the ten and eleven byte bounds, and raw binary bytes
	task automatic test_length_bounds();
		byte_q_t raw;
		send_byte(CHR_LF);
		send_text(nmea_text("GPGG", CS_GOOD));
		send_text(nmea_text("GPGGA", CS_GOOD));
		raw = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h00, CHR_LF};
		send_bytes(raw);
	endtask

	// line feed on the last place, and a sentence that fills the store
	// exactly with a good sum but no line feed, so it is cut at the limit
	task automatic test_line_store_full();
		string s;
		send_filler(LINE_MAX - 1);
		send_byte(CHR_LF);
		s = "GPRMC";
		while (s.len() < LINE_MAX - 6)
			s = $sformatf("%s,", s);
		s = nmea_text(s, CS_GOOD);
		s.putc(s.len() - 1, "\r");
		send_text(s);
		send_byte(CHR_LF);
	endtask

	// the sink holds off for a long time while short lines keep coming,
	// so both result stages fill and the byte input backs up
	task automatic test_backpressure();
		hold_off_req = 1'b1;
		tx_quiet = 1'b1;
		repeat (12)
			send_byte(CHR_LF);
		send_text(nmea_text("GPGSV,1,1,04", CS_GOOD));
		tx_quiet = 1'b0;
	endtask

	// mostly well-formed sentences with random content, plus short lines,
	// binary noise, damaged sentences and lines past the store limit
	task automatic test_random_traffic();
		int        start_bytes;
		int        start_lines;
		int        kind;
		int        idx;
		int        pick;
		string     s;
		cs_style_t style;
		byte_q_t   raw;
		byte_t     b;
		start_bytes = bytes_sent;
		start_lines = lines_predicted;
		while (bytes_sent - start_bytes < RAND_BYTES
			&& lines_predicted - start_lines < RAND_LINES) begin
			// stretches with no idling on either side
			if ($urandom_range(0, 9) == 0)
				tx_quiet = ~tx_quiet;
			if ($urandom_range(0, 9) == 0)
				rx_quiet = ~rx_quiet;
			kind = $urandom_range(0, 99);
			raw.delete();
			if (kind < 60) begin
				pick = $urandom_range(0, 9);
				style = (pick < 7) ? CS_GOOD : (pick < 9) ? CS_LOWER : CS_BAD;
				send_text(nmea_text(make_body($urandom_range(0, 40)), style));
			end else if (kind < 72) begin
				// short lines, around the ten byte bound
				repeat ($urandom_range(0, 12))
					raw.push_back(field_char());
				raw.push_back(CHR_LF);
				send_bytes(raw);
			end else if (kind < 84) begin
				// binary noise, which may hold its own line feeds
				repeat ($urandom_range(1, 60))
					raw.push_back(byte_t'($urandom_range(0, 255)));
				raw.push_back(CHR_LF);
				send_bytes(raw);
			end else if (kind < 96) begin
				// damaged sentence: one byte dropped or replaced
				s = nmea_text(make_body($urandom_range(0, 30)), CS_GOOD);
				idx = $urandom_range(0, s.len() - 2);
				if ($urandom_range(0, 1))
					s = {s.substr(0, idx - 1), s.substr(idx + 1, s.len() - 1)};
				else
					s.putc(idx, field_char());
				send_text(s);
			end else begin
				// around the store limit; a line past it is cut and the tail forms a line of its own
				repeat ($urandom_range(LINE_MAX - 8, LINE_MAX + 12)) begin
					b = byte_t'($urandom_range(0, 255));
					raw.push_back((b == CHR_LF) ? 8'h0B : b);
				end
				raw.push_back(CHR_LF);
				send_bytes(raw);
			end
		end
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------

	initial begin
		rx.valid   = 1'b0;
		rx.rx_byte = '0;
		arst_n     = 1'b0;
		clear_line();
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		test_header_types();
		test_checksum_faults();
		test_length_bounds();
		test_line_store_full();
		test_backpressure();
		test_random_traffic();

		// stop offering, let the last reports come out
		@(negedge clk);
		rx.valid = 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d bytes in %0d lines: %0d good checksums, %0d cut at the limit",
			bytes_sent, lines_checked, good_lines, full_lines);
		$display("byte input held back for %0d cycles, one result hold-off of %0d cycles",
			input_stalls, HOLD_CYCLES);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
